>>> rtl/core/rwes_pkg.sv
// ----------------------------------------------------------------------------
// Ring wave equation stepper package
// Shared types, field widths, register map and reset values.
// ----------------------------------------------------------------------------
package rwes_pkg;

	// Default sizing of the cell stores.
	localparam int MAX_CELLS_DEF  = 512;
	localparam int VALUE_BITS_DEF = 24;

	// Fixed field widths of the command and result channels.
	localparam int FRAC_BITS = 16;
	localparam int INDEX_W   = 9;
	localparam int FIELD_W   = 24;
	localparam int GAIN_W    = 24;
	localparam int STEP_W    = 16;
	localparam int COUNT_W   = 10;

	// Configuration port.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd655360;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd1092;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd500;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REG_LAPLACE_GAIN = 2'd0,
		REG_TIME_STEP    = 2'd1,
		REG_CELL_COUNT   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [INDEX_W-1:0]        cell_index;
		logic signed [FIELD_W-1:0] displacement_in;
	} request_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        cell_index_out;
		logic signed [FIELD_W-1:0] displacement_out;
		logic signed [FIELD_W-1:0] velocity_out;
	} result_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  laplace_gain;
		logic [STEP_W-1:0]  time_step;
		logic [COUNT_W-1:0] cell_count;
	} cfg_t;

	// A classified command as it waits in the queue.
	typedef struct packed {
		opcode_t                   opcode;
		logic [INDEX_W-1:0]        cell_index;
		logic signed [FIELD_W-1:0] displacement_in;
	} cmd_t;

endpackage

>>> rtl/core/rwes_front.sv
// ----------------------------------------------------------------------------
// Ring wave equation stepper front end
// Accepts requests, drops unused opcodes and pushes commands into the queue.
// ----------------------------------------------------------------------------
module rwes_front (
	input  logic              start,
	input  rwes_pkg::request_t request,
	input  logic              q_full,
	input  logic              clearing,
	output logic              busy,
	output logic              q_push,
	output rwes_pkg::cmd_t    q_data
);
	import rwes_pkg::*;

	logic accept;
	logic legal;

	// No request is taken while the stores are being cleared.
	assign busy   = q_full || clearing;
	assign accept = start && !busy;

	assign legal = (request.opcode == OP_WRITE) || (request.opcode == OP_STEP) ||
		(request.opcode == OP_READ);

	// An unused opcode is accepted and has no effect.
	assign q_push = accept && legal;

	assign q_data = '{
		opcode:          opcode_t'(request.opcode),
		cell_index:      request.cell_index,
		displacement_in: request.displacement_in
	};

endmodule

>>> rtl/core/rwes_queue.sv
// ----------------------------------------------------------------------------
// Ring wave equation stepper command queue
// Short FIFO that decouples request acceptance from execution.
// ----------------------------------------------------------------------------
module rwes_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rwes_pkg::cmd_t push_data,
	input  logic           pop,
	output rwes_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import rwes_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/rwes_back.sv
// ----------------------------------------------------------------------------
// Ring wave equation stepper back end
// Holds the cell stores, runs the clearing pass and executes commands; a
// step streams the ring through a five stage update pipeline.
// ----------------------------------------------------------------------------
module rwes_back #(
	parameter int MAX_CELLS  = rwes_pkg::MAX_CELLS_DEF,
	parameter int VALUE_BITS = rwes_pkg::VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rwes_pkg::cfg_t    cfg,
	input  rwes_pkg::cmd_t    head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              clearing,
	output logic              done,
	output rwes_pkg::result_t result
);
	import rwes_pkg::*;

	localparam int VB      = VALUE_BITS;
	localparam int IDX_W   = $clog2(MAX_CELLS);
	localparam int SLOT_W  = $clog2(MAX_CELLS + 2);
	localparam int LW      = VB + 2;
	localparam int LO_W    = (LW + 1) / 2;
	localparam int HI_W    = LW - LO_W;
	localparam int PLO_W   = LO_W + GAIN_W;
	localparam int PHI_W   = HI_W + GAIN_W;
	localparam int PW      = LW + GAIN_W;
	localparam int SW      = PW - FRAC_BITS + 1;
	localparam int DW      = VB + STEP_W + 1;
	localparam int DSW     = VB + 2;
	localparam int XW      = (VB > FIELD_W) ? VB : FIELD_W;
	localparam int OVF_BIT = 63;

	localparam logic signed [VB-1:0]      V_MAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0]      V_MIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  n_q;
	logic [SLOT_W-1:0]  n_eff;
	logic               rd_pend_q;
	logic               rd_ok_q;
	logic [INDEX_W-1:0] rd_idx_q;
	logic               done_q;
	result_t            result_q;

	// Cell stores.
	logic signed [VB-1:0] d_mem [MAX_CELLS];
	logic signed [VB-1:0] v_mem [MAX_CELLS];
	logic                 d_we;
	logic                 v_we;
	logic [IDX_W-1:0]     d_waddr;
	logic [IDX_W-1:0]     v_waddr;
	logic [IDX_W-1:0]     d_raddr;
	logic [IDX_W-1:0]     v_raddr;
	logic signed [VB-1:0] d_wdata;
	logic signed [VB-1:0] v_wdata;
	logic signed [VB-1:0] d_rdata;
	logic signed [VB-1:0] v_rdata;

	// Command decode.
	logic             head_ok;
	logic [IDX_W-1:0] head_addr;
	logic             pop_write;
	logic             pop_step;
	logic             pop_read;
	logic signed [XW-1:0] w_ext;
	logic signed [VB-1:0] w_val;

	// Sweep issue.
	logic             issue;
	logic             last_slot;
	logic [IDX_W-1:0] iss_addr;

	// Update pipeline.
	logic                    val_s1, val_s2, val_s3, val_s4, val_s5;
	logic                    use_d0_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic signed [VB-1:0]    d0_q, a_q, b_q;
	logic signed [VB-1:0]    din_s1;
	logic                    ctr_s1;
	logic [IDX_W-1:0]        ctr_idx;
	logic signed [LW-1:0]    lap_next;
	logic signed [LW-1:0]    lap_s2;
	logic [IDX_W-1:0]        idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [VB-1:0]    dold_s2, dold_s3, dold_s4, dold_s5;
	logic [PLO_W-1:0]        plo_s3;
	logic signed [PHI_W-1:0] phi_s3;
	logic signed [VB-1:0]    v_s3;
	logic signed [PW-1:0]    prod;
	logic                    ovf_pos, ovf_neg;
	logic signed [SW-1:0]    vsum;
	logic signed [VB-1:0]    v_sat;
	logic signed [VB-1:0]    vnew_s4;
	logic signed [DW-1:0]    pdt_s5;
	logic signed [DSW-1:0]   dsum;
	logic signed [VB-1:0]    d_sat;
	logic                    pipe_busy;

	// Read result.
	logic signed [XW-1:0]      rd_d_ext, rd_v_ext;
	logic signed [FIELD_W-1:0] rd_d_sat, rd_v_sat;

	// ------------------------------------------------------------------
	// Command decode
	// ------------------------------------------------------------------
	assign head_addr = IDX_W'(head.cell_index);
	assign head_ok   = int'(head.cell_index) < MAX_CELLS;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign pop_write = q_pop && (head.opcode == OP_WRITE);
	assign pop_step  = q_pop && (head.opcode == OP_STEP);
	assign pop_read  = q_pop && (head.opcode == OP_READ);
	assign clearing  = (state_q == ST_CLEAR);

	assign n_eff = (int'(cfg.cell_count) > MAX_CELLS) ? SLOT_W'(MAX_CELLS) :
		SLOT_W'(cfg.cell_count);

	// The written value is taken as 24 bit signed and saturated to the store width.
	always_comb begin
		w_ext = XW'(head.displacement_in);
		if ((&w_ext[XW-1:VB-1]) || !(|w_ext[XW-1:VB-1])) begin
			w_val = w_ext[VB-1:0];
		end else begin
			w_val = w_ext[XW-1] ? V_MIN : V_MAX;
		end
	end

	// ------------------------------------------------------------------
	// Sweep issue: slot 0 reads the last cell, slots 1 to n read cells 0 to
	// n-1, and slot n+1 replays the old value of cell 0 from a register.
	// ------------------------------------------------------------------
	assign issue     = (state_q == ST_ISSUE);
	assign last_slot = (slot_q == n_q + SLOT_W'(1));
	assign iss_addr  = (slot_q == '0) ? IDX_W'(n_q - SLOT_W'(1)) :
		IDX_W'(slot_q - SLOT_W'(1));

	assign pipe_busy = val_s1 || val_s2 || val_s3 || val_s4 || val_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			slot_q    <= '0;
			n_q       <= '0;
			rd_pend_q <= 1'b0;
			rd_ok_q   <= 1'b0;
			rd_idx_q  <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			rd_pend_q <= pop_read;
			if (pop_read) begin
				rd_idx_q <= head.cell_index;
				rd_ok_q  <= head_ok;
			end
			done_q <= rd_pend_q;
			if (rd_pend_q) begin
				result_q <= '{
					cell_index_out:   rd_idx_q,
					displacement_out: rd_ok_q ? rd_d_sat : '0,
					velocity_out:     rd_ok_q ? rd_v_sat : '0
				};
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop_step && (n_eff != '0)) begin
						n_q     <= n_eff;
						slot_q  <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					slot_q <= slot_q + SLOT_W'(1);
					if (last_slot) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Update pipeline
	// ------------------------------------------------------------------
	assign din_s1  = use_d0_s1 ? d0_q : d_rdata;
	assign ctr_s1  = val_s1 && (slot_s1 >= SLOT_W'(2));
	assign ctr_idx = IDX_W'(slot_s1 - SLOT_W'(2));

	// Laplacian of the center cell from its two old neighbours.
	assign lap_next = LW'(a_q) + LW'(din_s1) - (LW'(b_q) <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
		end else begin
			val_s1 <= issue;
			val_s2 <= ctr_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1   <= slot_q;
		use_d0_s1 <= last_slot;
		if (val_s1) begin
			a_q <= b_q;
			b_q <= din_s1;
			if (slot_s1 == SLOT_W'(1)) begin
				d0_q <= din_s1;
			end
		end
		lap_s2  <= lap_next;
		idx_s2  <= ctr_idx;
		dold_s2 <= b_q;

		// The Laplacian is split in two halves to keep each multiplier narrow.
		plo_s3  <= {{GAIN_W{1'b0}}, lap_s2[LO_W-1:0]} * {{LO_W{1'b0}}, cfg.laplace_gain};
		phi_s3  <= PHI_W'($signed(lap_s2[LW-1:LO_W])) *
			$signed({{HI_W{1'b0}}, cfg.laplace_gain});
		v_s3    <= v_rdata;
		idx_s3  <= idx_s2;
		dold_s3 <= dold_s2;

		vnew_s4 <= v_sat;
		idx_s4  <= idx_s3;
		dold_s4 <= dold_s3;

		pdt_s5  <= DW'(vnew_s4) * DW'($signed({1'b0, cfg.time_step}));
		idx_s5  <= idx_s4;
		dold_s5 <= dold_s4;
	end

	assign prod = (PW'(phi_s3) <<< LO_W) + PW'($signed({1'b0, plo_s3}));

	// A product at or beyond 2^63 in magnitude pins the velocity to its limit.
	generate
		if (PW > OVF_BIT + 1) begin : g_ovf
			assign ovf_pos = !prod[PW-1] && (|prod[PW-2:OVF_BIT]);
			assign ovf_neg = prod[PW-1] &&
				(!(&prod[PW-2:OVF_BIT]) || (prod[OVF_BIT-1:0] == '0));
		end else begin : g_no_ovf
			assign ovf_pos = 1'b0;
			assign ovf_neg = 1'b0;
		end
	endgenerate

	// Shifting the signed product right rounds toward minus infinity.
	assign vsum = SW'(v_s3) + SW'($signed(prod[PW-1:FRAC_BITS]));

	always_comb begin
		if (ovf_pos) begin
			v_sat = V_MAX;
		end else if (ovf_neg) begin
			v_sat = V_MIN;
		end else if ((&vsum[SW-1:VB-1]) || !(|vsum[SW-1:VB-1])) begin
			v_sat = vsum[VB-1:0];
		end else begin
			v_sat = vsum[SW-1] ? V_MIN : V_MAX;
		end
	end

	assign dsum = DSW'(dold_s5) + DSW'($signed(pdt_s5[DW-1:FRAC_BITS]));

	always_comb begin
		if ((&dsum[DSW-1:VB-1]) || !(|dsum[DSW-1:VB-1])) begin
			d_sat = dsum[VB-1:0];
		end else begin
			d_sat = dsum[DSW-1] ? V_MIN : V_MAX;
		end
	end

	// ------------------------------------------------------------------
	// Store ports
	// ------------------------------------------------------------------
	always_comb begin
		d_we    = 1'b0;
		d_waddr = head_addr;
		d_wdata = w_val;
		priority if (state_q == ST_CLEAR) begin
			d_we    = 1'b1;
			d_waddr = clr_q;
			d_wdata = '0;
		end else if (val_s5) begin
			d_we    = 1'b1;
			d_waddr = idx_s5;
			d_wdata = d_sat;
		end else if (pop_write && head_ok) begin
			d_we = 1'b1;
		end
	end

	assign v_we    = clearing || val_s4;
	assign v_waddr = clearing ? clr_q : idx_s4;
	assign v_wdata = clearing ? '0 : vnew_s4;

	assign d_raddr = issue ? iss_addr : head_addr;
	assign v_raddr = ctr_s1 ? ctr_idx : head_addr;

	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem[d_waddr] <= d_wdata;
		end
		d_rdata <= d_mem[d_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			v_mem[v_waddr] <= v_wdata;
		end
		v_rdata <= v_mem[v_raddr];
	end

	// ------------------------------------------------------------------
	// Read result, saturated to the 24 bit result fields
	// ------------------------------------------------------------------
	always_comb begin
		rd_d_ext = XW'(d_rdata);
		rd_v_ext = XW'(v_rdata);
		if ((&rd_d_ext[XW-1:FIELD_W-1]) || !(|rd_d_ext[XW-1:FIELD_W-1])) begin
			rd_d_sat = rd_d_ext[FIELD_W-1:0];
		end else begin
			rd_d_sat = rd_d_ext[XW-1] ? F_MIN : F_MAX;
		end
		if ((&rd_v_ext[XW-1:FIELD_W-1]) || !(|rd_v_ext[XW-1:FIELD_W-1])) begin
			rd_v_sat = rd_v_ext[FIELD_W-1:0];
		end else begin
			rd_v_sat = rd_v_ext[XW-1] ? F_MIN : F_MAX;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/ring_wave_equation_stepper_unit.sv
// ----------------------------------------------------------------------------
// Ring wave equation stepper unit
// The unit holds a ring of cells, each with a signed fixed point displacement
// and velocity, and takes three kinds of request: a write loads one
// displacement, a step advances the whole ring by one explicit time step of
// the 1-D wave equation, and a read returns one cell. A request is taken on
// a rising edge with start high and busy low; a read result appears on
// result with done high for exactly one cycle, and the receiver cannot hold
// it off. After reset the unit clears every cell of both stores with
// busy high; configuration writes are taken during that time. Up to two
// requests wait in a queue while the execution side works. A write stores
// its value as it leaves the queue, a read registers its result from the
// registered store outputs, and a step over n ring cells is swept one cell
// per cycle through the single read port of each store into a five stage
// update pipeline.
// ----------------------------------------------------------------------------
module ring_wave_equation_stepper_unit #(
	parameter int MAX_CELLS  = rwes_pkg::MAX_CELLS_DEF,
	parameter int VALUE_BITS = rwes_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rwes_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rwes_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rwes_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// Request channel.
	input  logic                              start,
	output logic                              busy,
	input  rwes_pkg::request_t                request,
	// Result channel.
	output logic                              done,
	output rwes_pkg::result_t                 result
);
	import rwes_pkg::*;

	logic [GAIN_W-1:0]  gain_q;
	logic [STEP_W-1:0]  dt_q;
	logic [COUNT_W-1:0] count_q;
	logic [1:0]         reg_sel;
	logic               cfg_wr;
	cfg_t               cfg;

	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;
	cmd_t q_in;
	cmd_t q_head;
	logic clearing;

	// ------------------------------------------------------------------
	// Configuration registers. Each register sits on a 32 bit word; the
	// port never inserts wait states.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			dt_q    <= STEP_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_LAPLACE_GAIN: gain_q  <= pwdata[GAIN_W-1:0];
				REG_TIME_STEP:    dt_q    <= pwdata[STEP_W-1:0];
				REG_CELL_COUNT:   count_q <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LAPLACE_GAIN: prdata = APB_DATA_W'(gain_q);
			REG_TIME_STEP:    prdata = APB_DATA_W'(dt_q);
			REG_CELL_COUNT:   prdata = APB_DATA_W'(count_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg = '{laplace_gain: gain_q, time_step: dt_q, cell_count: count_q};

	// ------------------------------------------------------------------
	// The front classifies each request and queues it; the back executes
	// queued commands one at a time against the cell stores.
	// ------------------------------------------------------------------
	rwes_front u_front (
		.start    (start),
		.request  (request),
		.q_full   (q_full),
		.clearing (clearing),
		.busy     (busy),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	rwes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	rwes_back #(
		.MAX_CELLS  (MAX_CELLS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule
